FILE: hdl/sssb_pkg.sv
// Shared types, constants and the digit pattern table of the segment display driver.
`timescale 1ns / 1ps
`default_nettype none

package sssb_pkg;

  typedef enum logic [1:0] {
    REQ_NUMBER  = 2'd0,
    REQ_GEAR    = 2'd1,
    REQ_BREATHE = 2'd2,
    REQ_TICK    = 2'd3
  } sssb_req_e;

  localparam int unsigned NumPos    = 3;
  localparam int unsigned IvW       = 9;
  localparam int unsigned LevelW    = 7;
  localparam logic [6:0]  DutyFull  = 7'd100;
  localparam logic [7:0]  HundMark  = 8'h0c;
  localparam logic [7:0]  NumMask0  = 8'hfc;
  localparam logic [7:0]  NumMask2  = 8'h0e;
  localparam logic [7:0]  GearBits  = 8'hc0;
  localparam logic [7:0]  RampBit   = 8'h02;
  // floor(x / 25) == (x * DivRecip) >> DivShift for every 13-bit x.
  localparam logic [15:0] DivRecip  = 16'd41944;
  localparam int unsigned DivShift  = 20;

  // Result of the per-item arithmetic on the value field.
  typedef struct packed {
    logic [7:0]     tens_pat;
    logic [7:0]     ones_pat;
    logic           hundreds;
    logic [IvW-1:0] interval;
  } sssb_calc_t;

  // One result transaction.
  typedef struct packed {
    logic [2:0] digit_enable;
    logic [5:0] segment_lines;
    logic [6:0] pwm_duty;
    logic       red_on;
    logic       yellow_on;
  } sssb_rsp_t;

  function automatic logic [7:0] digit_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'h7e;
      4'd1:    pat = 8'h0c;
      4'd2:    pat = 8'he6;
      4'd3:    pat = 8'hce;
      4'd4:    pat = 8'h9c;
      4'd5:    pat = 8'hda;
      4'd6:    pat = 8'hfa;
      4'd7:    pat = 8'h4c;
      4'd8:    pat = 8'hfe;
      4'd9:    pat = 8'hde;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sssb_req_if.sv
// Request channel: valid/ready handshake carrying request kind and value.
`timescale 1ns / 1ps
`default_nettype none

interface sssb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

FILE: hdl/sssb_rsp_if.sv
// Result channel: valid/ready handshake carrying the display drive and lamp outputs.
`timescale 1ns / 1ps
`default_nettype none

interface sssb_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] digit_enable;
  logic [5:0] segment_lines;
  logic [6:0] pwm_duty;
  logic       red_on;
  logic       yellow_on;

  modport source (output valid, output digit_enable, output segment_lines,
                  output pwm_duty, output red_on, output yellow_on, input ready);
  modport sink   (input valid, input digit_enable, input segment_lines,
                  input pwm_duty, input red_on, input yellow_on, output ready);
endinterface

`default_nettype wire

FILE: hdl/sssb_calc.sv
// Value arithmetic: digit split of a number and breathe interval from a period.
`timescale 1ns / 1ps
`default_nettype none

module sssb_calc (
  input  wire logic [15:0]         value_i,
  output sssb_pkg::sssb_calc_t     calc_o
);
  import sssb_pkg::*;

  logic [7:0]  num;
  logic [15:0] q_prod;
  logic [4:0]  q10;
  logic [7:0]  q10_times;
  logic [3:0]  ones;
  logic [3:0]  tens;
  logic [12:0] per8;
  logic [28:0] iv_prod;
  logic [IvW-1:0] iv_raw;

  always_comb begin
    num       = value_i[7:0];
    // n / 10 for n < 256 by reciprocal multiplication.
    q_prod    = 16'(num) * 16'd205;
    q10       = q_prod[15:11];
    q10_times = 8'(q10) * 8'd10;
    ones      = 4'(num - q10_times);
    if (q10 >= 5'd20) begin
      tens = 4'(q10 - 5'd20);
    end else if (q10 >= 5'd10) begin
      tens = 4'(q10 - 5'd10);
    end else begin
      tens = q10[3:0];
    end

    // period / 200 is (period / 8) / 25.
    per8    = value_i[15:3];
    iv_prod = 29'(per8) * 29'(DivRecip);
    iv_raw  = iv_prod[DivShift +: IvW];

    calc_o.tens_pat = digit_pattern(tens);
    calc_o.ones_pat = digit_pattern(ones);
    calc_o.hundreds = (num >= 8'd100);
    calc_o.interval = (iv_raw == '0) ? IvW'(1) : iv_raw;
  end

endmodule

`default_nettype wire

FILE: hdl/sssb_state.sv
// Display, lamp, ramp and scan state with its per-transaction update.
`timescale 1ns / 1ps
`default_nettype none

module sssb_state #(
  parameter int unsigned REFRESH_MS = 5
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 fire_i,
  input  wire logic [1:0]           req_type_i,
  input  wire logic [15:0]          value_i,
  input  wire sssb_pkg::sssb_calc_t calc_i,
  output sssb_pkg::sssb_rsp_t       rsp_o
);
  import sssb_pkg::*;

  localparam int unsigned RefW = (REFRESH_MS > 1) ? $clog2(REFRESH_MS) : 1;
  localparam logic [RefW:0] RefreshLast = (RefW + 1)'(REFRESH_MS);

  logic [7:0]        db_q [NumPos];
  logic [7:0]        db_d [NumPos];
  logic [1:0]        pos_q, pos_d;
  logic [RefW-1:0]   ref_cnt_q, ref_cnt_d;
  logic [7:0]        step_q, step_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [IvW-1:0]    interval_q, interval_d;
  logic [IvW-1:0]    ramp_cnt_q, ramp_cnt_d;
  logic              running_q, running_d;
  logic [1:0]        lamps_q, lamps_d;
  logic [2:0]        dig_q, dig_d;
  logic [5:0]        seg_q, seg_d;
  logic [6:0]        duty_q, duty_d;
  logic [7:0]        step_inc;
  logic [7:0]        cur_byte;

  always_comb begin
    for (int i = 0; i < NumPos; i++) begin
      db_d[i] = db_q[i];
    end
    pos_d      = pos_q;
    ref_cnt_d  = ref_cnt_q;
    step_d     = step_q;
    level_d    = level_q;
    interval_d = interval_q;
    ramp_cnt_d = ramp_cnt_q;
    running_d  = running_q;
    lamps_d    = lamps_q;
    dig_d      = dig_q;
    seg_d      = seg_q;
    duty_d     = duty_q;
    step_inc   = step_q + 8'd1;
    cur_byte   = 8'h00;

    case (sssb_req_e'(req_type_i))
      REQ_NUMBER: begin
        db_d[0] = (db_q[0] & ~NumMask0) | (calc_i.hundreds ? HundMark : 8'h00)
                  | (calc_i.tens_pat & 8'hf0);
        db_d[1] = (calc_i.tens_pat & 8'h0f) | (calc_i.ones_pat & 8'hf0);
        db_d[2] = (db_q[2] & ~NumMask2) | (calc_i.ones_pat & 8'h0f);
      end
      REQ_GEAR: begin
        // Gears above three leave everything as it is.
        if (value_i[15:2] == '0) begin
          case (value_i[1:0])
            2'd3:    lamps_d = 2'b01;
            2'd2:    lamps_d = 2'b10;
            default: lamps_d = 2'b00;
          endcase
          if (value_i[1:0] == 2'd1) begin
            db_d[2] = db_q[2] | GearBits;
          end else begin
            db_d[2] = db_q[2] & ~GearBits;
          end
        end
      end
      REQ_BREATHE: begin
        if (value_i != '0) begin
          interval_d = calc_i.interval;
          ramp_cnt_d = calc_i.interval;
          running_d  = 1'b1;
          db_d[0]    = db_q[0] | RampBit;
        end else begin
          running_d  = 1'b0;
          db_d[0]    = db_q[0] & ~RampBit;
        end
      end
      REQ_TICK: begin
        // The ramp moves first so that a refresh on the same tick sees the new level.
        if (running_q) begin
          if (ramp_cnt_q <= IvW'(1)) begin
            ramp_cnt_d = interval_q;
            step_d     = step_inc;
            if (step_inc > 8'd0 && step_inc < 8'd100) begin
              level_d = step_inc[LevelW-1:0];
            end else if (step_inc >= 8'd100 && step_inc < 8'd200) begin
              level_d = LevelW'(8'd200 - step_inc);
            end else if (step_inc == 8'd200) begin
              step_d  = 8'd0;
              level_d = '0;
            end
          end else begin
            ramp_cnt_d = ramp_cnt_q - IvW'(1);
          end
        end

        if ((RefW + 1)'(ref_cnt_q) + (RefW + 1)'(1) >= RefreshLast) begin
          ref_cnt_d = '0;
          pos_d     = (pos_q >= 2'd2) ? 2'd0 : pos_q + 2'd1;
          case (pos_d)
            2'd1:    cur_byte = db_q[1];
            2'd2:    cur_byte = db_q[2];
            default: cur_byte = db_q[0];
          endcase
          dig_d = 3'(3'b001 << pos_d);
          seg_d = ~cur_byte[7:2];
          if (cur_byte[1]) begin
            duty_d = (pos_d == 2'd0) ? level_d : 7'd0;
          end else begin
            duty_d = DutyFull;
          end
        end else begin
          ref_cnt_d = ref_cnt_q + RefW'(1);
        end
      end
      default: ;
    endcase

    rsp_o.digit_enable  = dig_d;
    rsp_o.segment_lines = seg_d;
    rsp_o.pwm_duty      = duty_d;
    rsp_o.red_on        = lamps_d[0];
    rsp_o.yellow_on     = lamps_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPos; i++) begin
        db_q[i] <= 8'h00;
      end
      pos_q      <= '0;
      ref_cnt_q  <= '0;
      step_q     <= '0;
      level_q    <= '0;
      interval_q <= '0;
      ramp_cnt_q <= '0;
      running_q  <= 1'b0;
      lamps_q    <= '0;
      dig_q      <= '0;
      seg_q      <= '0;
      duty_q     <= '0;
    end else if (fire_i) begin
      for (int i = 0; i < NumPos; i++) begin
        db_q[i] <= db_d[i];
      end
      pos_q      <= pos_d;
      ref_cnt_q  <= ref_cnt_d;
      step_q     <= step_d;
      level_q    <= level_d;
      interval_q <= interval_d;
      ramp_cnt_q <= ramp_cnt_d;
      running_q  <= running_d;
      lamps_q    <= lamps_d;
      dig_q      <= dig_d;
      seg_q      <= seg_d;
      duty_q     <= duty_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/seven_segment_scan_with_breathing_led_top.sv
// Top level of the three-position scanned segment display driver with breathing indicator.
`timescale 1ns / 1ps
`default_nettype none

// Each request transaction (number write, gear write, breathe write or 1 ms tick)
// produces exactly one result transaction carrying the latched digit enable,
// active-low segment lines, indicator PWM duty and the red/yellow lamp drives.
// A request is captured in an input register and processed from it into the result
// register whenever that register is free, and one request can be
// accepted every cycle; the result register decouples the two sides, and
// throughput drops only while the result side holds ready low. The scan position
// advances every REFRESH_MS ticks (1 to 100), and a breathe period P ms steps the
// triangle duty every max(1, P / 200) ticks.
module seven_segment_scan_with_breathing_led_top #(
  parameter int unsigned REFRESH_MS = 5
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sssb_req_if.sink  req_i,
  sssb_rsp_if.source rsp_o
);
  import sssb_pkg::*;

  logic        in_vld_q;
  logic [1:0]  in_type_q;
  logic [15:0] in_value_q;
  logic        out_vld_q;
  sssb_rsp_t   out_q;
  sssb_rsp_t   rsp_next;
  sssb_calc_t  calc;
  logic        out_free;
  logic        fire;

  assign out_free    = !out_vld_q || rsp_o.ready;
  assign fire        = in_vld_q && out_free;
  assign req_i.ready = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_type_q  <= req_i.req_type;
      in_value_q <= req_i.value;
    end
  end

  sssb_calc u_calc (
    .value_i (in_value_q),
    .calc_o  (calc)
  );

  sssb_state #(
    .REFRESH_MS (REFRESH_MS)
  ) u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .req_type_i (in_type_q),
    .value_i    (in_value_q),
    .calc_i     (calc),
    .rsp_o      (rsp_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= rsp_next;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.digit_enable  = out_q.digit_enable;
  assign rsp_o.segment_lines = out_q.segment_lines;
  assign rsp_o.pwm_duty      = out_q.pwm_duty;
  assign rsp_o.red_on        = out_q.red_on;
  assign rsp_o.yellow_on     = out_q.yellow_on;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the scanned segment display driver with breathing indicator.
`timescale 1ns / 1ps

module tb_top;
  import sssb_pkg::*;

  localparam int unsigned REFRESH_TICKS = 5;
  localparam int unsigned PHASE_ITEMS   = 100;

  localparam logic [7:0] DIGIT_SEGS [10] = '{
    8'h7e, 8'h0c, 8'he6, 8'hce, 8'h9c, 8'hda, 8'hfa, 8'h4c, 8'hfe, 8'hde
  };

  typedef struct packed {
    sssb_req_e   kind;
    logic [15:0] value;
  } display_req_t;

  logic clk_i;
  logic rst_ni;

  sssb_req_if req ();
  sssb_rsp_if rsp ();

  seven_segment_scan_with_breathing_led_top #(
    .REFRESH_MS(REFRESH_TICKS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  display_req_t pending_reqs[$];
  sssb_rsp_t    drive_expected[$];
  int unsigned  err_count;
  int unsigned  send_idle_pct;
  int unsigned  stall_pct;

  // Shadow copy of the display, scan and ramp state.
  logic [7:0]  seg_bytes [3];
  logic [1:0]  scan_pos;
  int unsigned refresh_ticks;
  logic [7:0]  ramp_step;
  logic [6:0]  ramp_level;
  logic [8:0]  ramp_interval;
  logic [8:0]  ramp_count;
  logic        ramp_on;
  logic [1:0]  lamps;
  logic [2:0]  drv_enable;
  logic [5:0]  drv_seg;
  logic [6:0]  drv_duty;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic queue_req(input sssb_req_e kind, input logic [15:0] value);
    display_req_t item;
    item.kind  = kind;
    item.value = value;
    pending_reqs.push_back(item);
  endtask

  // Applies one request to the shadow state and returns the drive it should report.
  function automatic sssb_rsp_t predict_drive(input sssb_req_e kind, input logic [15:0] value);
    logic [7:0]  num;
    logic [7:0]  tens_pat;
    logic [7:0]  ones_pat;
    logic [7:0]  pos_byte;
    logic [1:0]  pos;
    logic [15:0] iv;
    sssb_rsp_t   r;
    case (kind)
      REQ_NUMBER: begin
        num = value[7:0];
        tens_pat = DIGIT_SEGS[(num / 10) % 10];
        ones_pat = DIGIT_SEGS[num % 10];
        seg_bytes[0] &= ~8'hfc;
        seg_bytes[2] &= ~8'h0e;
        if (num >= 8'd100) begin
          seg_bytes[0] |= 8'h0c;
        end
        seg_bytes[0] |= tens_pat & 8'hf0;
        seg_bytes[1] = {ones_pat[7:4], tens_pat[3:0]};
        seg_bytes[2] |= {4'h0, ones_pat[3:0]};
      end
      REQ_GEAR: begin
        if (value <= 16'd3) begin
          if (value == 16'd3) begin
            lamps = 2'b01;
          end else if (value == 16'd2) begin
            lamps = 2'b10;
          end else begin
            lamps = 2'b00;
          end
          if (value == 16'd1) begin
            seg_bytes[2] |= 8'hc0;
          end else begin
            seg_bytes[2] &= ~8'hc0;
          end
        end
      end
      REQ_BREATHE: begin
        if (value != 16'd0) begin
          iv = value / 16'd200;
          if (iv == 16'd0) begin
            iv = 16'd1;
          end
          ramp_interval = iv[8:0];
          ramp_count    = iv[8:0];
          ramp_on       = 1'b1;
          seg_bytes[0] |= 8'h02;
        end else begin
          ramp_on = 1'b0;
          seg_bytes[0] &= ~8'h02;
        end
      end
      default: begin
        // The ramp moves before the refresh, so a refresh sees the new level.
        if (ramp_on) begin
          if (ramp_count <= 9'd1) begin
            ramp_step++;
            if (ramp_step > 8'd0 && ramp_step < 8'd100) begin
              ramp_level = ramp_step[6:0];
            end else if (ramp_step >= 8'd100 && ramp_step < 8'd200) begin
              ramp_level = 7'(8'd200 - ramp_step);
            end else if (ramp_step == 8'd200) begin
              ramp_step  = 8'd0;
              ramp_level = 7'd0;
            end
            ramp_count = ramp_interval;
          end else begin
            ramp_count--;
          end
        end
        if (refresh_ticks + 1 >= REFRESH_TICKS) begin
          refresh_ticks = 0;
          pos = (scan_pos >= 2'd2) ? 2'd0 : scan_pos + 2'd1;
          pos_byte = seg_bytes[pos];
          scan_pos = pos;
          if (pos_byte[1]) begin
            drv_duty = (pos == 2'd0) ? ramp_level : 7'd0;
          end else begin
            drv_duty = 7'd100;
          end
          drv_enable = 3'b001 << pos;
          drv_seg    = ~pos_byte[7:2];
        end else begin
          refresh_ticks++;
        end
      end
    endcase
    r.digit_enable  = drv_enable;
    r.segment_lines = drv_seg;
    r.pwm_duty      = drv_duty;
    r.red_on        = lamps[0];
    r.yellow_on     = lamps[1];
    return r;
  endfunction

  // Request driver.
  always @(posedge clk_i) begin : req_driver
    display_req_t item;
    if (!rst_ni) begin
      req.valid    <= 1'b0;
      req.req_type <= REQ_NUMBER;
      req.value    <= 16'd0;
    end else if (!req.valid || req.ready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item = pending_reqs.pop_front();
        req.valid    <= 1'b1;
        req.req_type <= item.kind;
        req.value    <= item.value;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk_i) begin : rsp_stall
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Predicts on each accepted request and checks each accepted result in order.
  always @(posedge clk_i) begin : monitor
    sssb_rsp_t got;
    sssb_rsp_t want;
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        drive_expected.push_back(predict_drive(sssb_req_e'(req.req_type), req.value));
      end
      if (rsp.valid && rsp.ready) begin
        got.digit_enable  = rsp.digit_enable;
        got.segment_lines = rsp.segment_lines;
        got.pwm_duty      = rsp.pwm_duty;
        got.red_on        = rsp.red_on;
        got.yellow_on     = rsp.yellow_on;
        if (drive_expected.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = drive_expected.pop_front();
          if (got.digit_enable !== want.digit_enable) begin
            report_mismatch($sformatf("digit_enable %b, expected %b",
                                      got.digit_enable, want.digit_enable));
          end
          if (got.segment_lines !== want.segment_lines) begin
            report_mismatch($sformatf("segment_lines %b, expected %b",
                                      got.segment_lines, want.segment_lines));
          end
          if (got.pwm_duty !== want.pwm_duty) begin
            report_mismatch($sformatf("pwm_duty %0d, expected %0d",
                                      got.pwm_duty, want.pwm_duty));
          end
          if (got.red_on !== want.red_on) begin
            report_mismatch($sformatf("red_on %b, expected %b", got.red_on, want.red_on));
          end
          if (got.yellow_on !== want.yellow_on) begin
            report_mismatch($sformatf("yellow_on %b, expected %b",
                                      got.yellow_on, want.yellow_on));
          end
        end
      end
    end
  end

  initial begin : run_limit
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick;
    logic [15:0] val;
    rst_ni       = 1'b0;
    req.valid    = 1'b0;
    req.req_type = REQ_NUMBER;
    req.value    = 16'd0;
    rsp.ready    = 1'b0;
    err_count     = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int i = 0; i < 3; i++) begin
      seg_bytes[i] = 8'd0;
    end
    scan_pos      = 2'd0;
    refresh_ticks = 0;
    ramp_step     = 8'd0;
    ramp_level    = 7'd0;
    ramp_interval = 9'd0;
    ramp_count    = 9'd0;
    ramp_on       = 1'b0;
    lamps         = 2'b00;
    drv_enable    = 3'd0;
    drv_seg       = 6'd0;
    drv_duty      = 7'd0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: field extremes, gears out of range, breathe edges.
    queue_req(REQ_NUMBER, 16'hff00);
    queue_req(REQ_BREATHE, 16'd1);
    for (int i = 0; i < 5; i++) begin
      queue_req(REQ_TICK, 16'd0);
    end
    queue_req(REQ_NUMBER, 16'd255);
    queue_req(REQ_NUMBER, 16'd100);
    queue_req(REQ_NUMBER, 16'd99);
    queue_req(REQ_GEAR, 16'd1);
    queue_req(REQ_GEAR, 16'd4);
    queue_req(REQ_GEAR, 16'hffff);
    queue_req(REQ_GEAR, 16'd3);
    queue_req(REQ_GEAR, 16'd2);
    queue_req(REQ_BREATHE, 16'd199);
    queue_req(REQ_BREATHE, 16'd200);
    queue_req(REQ_BREATHE, 16'hffff);
    queue_req(REQ_BREATHE, 16'd0);
    queue_req(REQ_BREATHE, 16'd400);
    queue_req(REQ_GEAR, 16'd0);
    for (int i = 0; i < 5; i++) begin
      queue_req(REQ_TICK, 16'hffff);
    end

    // Random part in four phases of differing idling and stalling; each phase drains before the next starts.
    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        send_idle_pct = (phase == 2) ? 48 : (phase == 4) ? 37 : 0;
        stall_pct     = (phase == 3) ? 48 : (phase == 4) ? 37 : 0;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          pick = $urandom_range(99);
          val  = 16'($urandom_range(65535));
          if (pick < 75) begin
            queue_req(REQ_TICK, val);
          end else if (pick < 84) begin
            queue_req(REQ_NUMBER, val);
          end else if (pick < 92) begin
            queue_req(REQ_GEAR, ($urandom_range(3) == 0) ? val : 16'($urandom_range(3)));
          end else begin
            // Mostly short periods so the ramp actually travels; some stops.
            pick = $urandom_range(9);
            if (pick < 2) begin
              queue_req(REQ_BREATHE, 16'd0);
            end else if (pick < 8) begin
              queue_req(REQ_BREATHE, 16'($urandom_range(599, 1)));
            end else begin
              queue_req(REQ_BREATHE, val);
            end
          end
        end
      end
      while (pending_reqs.size() > 0 || req.valid || drive_expected.size() > 0) begin
        @(negedge clk_i);
      end
    end

    repeat (8) @(posedge clk_i);
    if (drive_expected.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", drive_expected.size()));
    end
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
